>>> hw/rtl/modbus_rtu_response_checker_assert.svh
// assertion macros for the modbus rtu response checker
`ifndef MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrc same-cycle check failed");

// next-cycle implication, checked out of reset
`define MRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrc next-cycle check failed");

`endif

>>> hw/rtl/mrc_pkg.sv
// shared types, codes and crc function of the modbus rtu response checker
package mrc_pkg;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ADDR_FUNC   = 3'd1;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
  localparam logic [2:0] ST_COUNT       = 3'd3;
  localparam logic [2:0] ST_CRC         = 3'd4;

  localparam logic [7:0] FN_READ_HOLDING = 8'd3;
  localparam logic [7:0] FN_READ_INPUT   = 8'd4;

  localparam logic [1:0] REG_EXP_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_EXP_FUNCTION = 2'd1;
  localparam logic [1:0] REG_REQ_COUNT    = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [7:0] exp_address;
    logic [7:0] exp_function;
    logic [6:0] req_count;
  } cfg_t;

  typedef struct packed {
    logic [15:0] crc;
    logic [2:0]  status;
  } result_t;

  // crc-16/modbus over one byte, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/mrc_cfg_regs.sv
// configuration registers of the modbus rtu response checker
module mrc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [1:0]    wr_index,
  input  logic [7:0]    wr_data,
  output mrc_pkg::cfg_t cfg
);
  import mrc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_EXP_ADDRESS:  cfg_r.exp_address  <= wr_data;
        REG_EXP_FUNCTION: cfg_r.exp_function <= wr_data;
        REG_REQ_COUNT:    cfg_r.req_count    <= wr_data[6:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/mrc_frame_ctl.sv
// frame tracking, field checks and crc accumulation, one byte per step
module mrc_frame_ctl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  input  mrc_pkg::cfg_t    cfg,
  output logic             res_valid,
  output mrc_pkg::result_t res
);
  import mrc_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  rcount_r, rcount_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        done_r, done_nxt;

  logic        active;
  logic [15:0] cur_crc;
  logic [8:0]  cur_pos;
  logic [7:0]  cur_rcount;
  logic [2:0]  cur_err;
  logic [7:0]  cur_lo;
  logic [15:0] crc_upd;
  logic [8:0]  data_end;
  logic [2:0]  fn_err;

  // a start byte sees a freshly cleared frame
  assign active     = step_en && (frame_start || !done_r);
  assign cur_crc    = frame_start ? CRC_INIT : crc_r;
  assign cur_pos    = frame_start ? 9'd0 : pos_r;
  assign cur_rcount = frame_start ? 8'd0 : rcount_r;
  assign cur_err    = frame_start ? ST_OK : err_r;
  assign cur_lo     = frame_start ? 8'd0 : crc_lo_r;
  assign crc_upd    = crc16_byte(cur_crc, rx_byte);
  assign data_end   = {1'b0, cur_rcount} + 9'd3;

  always_comb begin
    if (rx_byte != cfg.exp_function) begin
      fn_err = ST_ADDR_FUNC;
    end else if (cur_err == ST_OK && rx_byte != FN_READ_HOLDING &&
                 rx_byte != FN_READ_INPUT) begin
      fn_err = ST_UNSUPPORTED;
    end else begin
      fn_err = cur_err;
    end
  end

  always_comb begin
    crc_nxt    = crc_r;
    pos_nxt    = pos_r;
    rcount_nxt = rcount_r;
    err_nxt    = err_r;
    crc_lo_nxt = crc_lo_r;
    done_nxt   = done_r;
    res_valid  = 1'b0;
    res.status = err_r;
    res.crc    = crc_r;
    if (active) begin
      crc_nxt    = cur_crc;
      rcount_nxt = cur_rcount;
      err_nxt    = cur_err;
      crc_lo_nxt = cur_lo;
      done_nxt   = 1'b0;
      if (cur_pos == 9'd0) begin
        err_nxt = (rx_byte != cfg.exp_address) ? ST_ADDR_FUNC : cur_err;
        crc_nxt = crc_upd;
        pos_nxt = 9'd1;
      end else if (cur_pos == 9'd1) begin
        err_nxt = fn_err;
        crc_nxt = crc_upd;
        pos_nxt = 9'd2;
        if (fn_err != ST_OK) begin
          res_valid  = 1'b1;
          res.status = fn_err;
          res.crc    = crc_upd;
          done_nxt   = 1'b1;
        end
      end else if (cur_pos == 9'd2) begin
        rcount_nxt = rx_byte;
        crc_nxt    = crc_upd;
        pos_nxt    = 9'd3;
        if (rx_byte[7:1] != cfg.req_count) begin
          err_nxt    = ST_COUNT;
          res_valid  = 1'b1;
          res.status = ST_COUNT;
          res.crc    = crc_upd;
          done_nxt   = 1'b1;
        end
      end else if (cur_pos < data_end) begin
        crc_nxt = crc_upd;
        pos_nxt = cur_pos + 9'd1;
      end else if (cur_pos == data_end) begin
        crc_lo_nxt = rx_byte;
        pos_nxt    = cur_pos + 9'd1;
      end else begin
        // high crc byte: compare both received crc bytes
        err_nxt    = (cur_lo != cur_crc[7:0] || rx_byte != cur_crc[15:8]) ? ST_CRC : ST_OK;
        res_valid  = 1'b1;
        res.status = err_nxt;
        res.crc    = cur_crc;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      pos_r    <= '0;
      rcount_r <= '0;
      err_r    <= ST_OK;
      crc_lo_r <= '0;
      done_r   <= 1'b1;
    end else begin
      crc_r    <= crc_nxt;
      pos_r    <= pos_nxt;
      rcount_r <= rcount_nxt;
      err_r    <= err_nxt;
      crc_lo_r <= crc_lo_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

>>> hw/rtl/modbus_rtu_response_checker.sv
// top level of the modbus rtu response checker: input register, frame logic, result register
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tdata rx_byte, tuser frame_start
//  out_     out  out_tvalid/out_tready  tdata status, computed_crc
//  cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one byte per cycle sustained while the result side is not stalled; a verdict is registered in the result register
// the byte-wide crc update and field checks sit between the input and result registers
// reset clears the frame state to idle; bytes are ignored until a frame start
// a stalled result holds the pipe, the input register still fills behind it
// cfg_ready is always high
`include "modbus_rtu_response_checker_assert.svh"

module modbus_rtu_response_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] status, [18:3] computed_crc, [23:19] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import mrc_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       out_vld_r;
  result_t    out_res_r;
  logic       adv;
  logic       step;

  assign cfg_ready = 1'b1;

  mrc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // pipe moves when the result slot is free or being drained
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;
  assign step      = in_vld_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser[0];
    end
  end

  mrc_frame_ctl u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step),
    .rx_byte     (in_byte_r),
    .frame_start (in_start_r),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_res_r.crc, out_res_r.status};

  `MRC_ASSERT_NOW(a_status_range, out_vld_r, out_res_r.status <= ST_CRC)
  `MRC_ASSERT_NOW(a_empty_stage_ready, !in_vld_r, in_tready)
  `MRC_ASSERT_NEXT(a_stalled_byte_held, in_vld_r && !adv, in_vld_r && $stable(in_byte_r))

endmodule

>>> tb/modbus_rtu_response_checker_monitor.sv
// checker for the modbus rtu response checker testbench, with its crc helper package
`timescale 1ns / 100ps

package mrc_tb_pkg;
  import mrc_pkg::*;

  // crc-16/modbus, one data bit at a time, lsb first
  function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc,
                                                  input logic [7:0]  b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction
endpackage

module modbus_rtu_response_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [2:0] status, [18:3] computed_crc, [23:19] zero
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          verdicts_due
);
  import mrc_pkg::*;
  import mrc_tb_pkg::*;

  // request the block is set up for
  logic [7:0] exp_addr;
  logic [7:0] exp_func;
  logic [6:0] exp_regs;

  // frame tracking
  logic [15:0] crc_acc;
  int          byte_idx;
  logic [7:0]  len_byte;
  logic [2:0]  verdict_code;
  logic [7:0]  crc_lo_seen;
  bit          frame_closed;

  result_t pending_verdicts[$];

  // advances the frame by one received byte; returns 1 when the byte closes the frame
  function automatic bit judge_byte(input logic [7:0] rx, input bit start, output result_t v);
    v = '0;
    if (start) begin
      crc_acc      = CRC_INIT;
      byte_idx     = 0;
      len_byte     = '0;
      verdict_code = ST_OK;
      crc_lo_seen  = '0;
      frame_closed = 1'b0;
    end else if (frame_closed) begin
      return 1'b0;
    end

    if (byte_idx == 0) begin
      if (rx != exp_addr) begin
        verdict_code = ST_ADDR_FUNC;
      end
      crc_acc  = modbus_crc_next(crc_acc, rx);
      byte_idx = 1;
      return 1'b0;
    end

    if (byte_idx == 1) begin
      if (rx != exp_func) begin
        verdict_code = ST_ADDR_FUNC;
      end else if (verdict_code == ST_OK && rx != FN_READ_HOLDING && rx != FN_READ_INPUT) begin
        verdict_code = ST_UNSUPPORTED;
      end
      crc_acc  = modbus_crc_next(crc_acc, rx);
      byte_idx = 2;
      if (verdict_code == ST_OK) begin
        return 1'b0;
      end
    end else if (byte_idx == 2) begin
      len_byte = rx;
      crc_acc  = modbus_crc_next(crc_acc, rx);
      byte_idx = 3;
      if (rx[7:1] == exp_regs) begin
        return 1'b0;
      end
      verdict_code = ST_COUNT;
    end else if (byte_idx < len_byte + 3) begin
      crc_acc  = modbus_crc_next(crc_acc, rx);
      byte_idx = byte_idx + 1;
      return 1'b0;
    end else if (byte_idx == len_byte + 3) begin
      crc_lo_seen = rx;
      byte_idx    = byte_idx + 1;
      return 1'b0;
    end else begin
      verdict_code = (crc_lo_seen == crc_acc[7:0] && rx == crc_acc[15:8]) ? ST_OK : ST_CRC;
    end

    v.status     = verdict_code;
    v.crc        = crc_acc;
    frame_closed = 1'b1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    result_t fresh;
    result_t want;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      exp_addr     = '0;
      exp_func     = '0;
      exp_regs     = '0;
      crc_acc      = CRC_INIT;
      byte_idx     = 0;
      len_byte     = '0;
      verdict_code = ST_OK;
      crc_lo_seen  = '0;
      frame_closed = 1'b1;
      pending_verdicts.delete();
      fail_count   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXP_ADDRESS:  exp_addr = cfg_data;
          REG_EXP_FUNCTION: exp_func = cfg_data;
          REG_REQ_COUNT:    exp_regs = cfg_data[6:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        if (judge_byte(in_tdata, in_tuser[0], fresh)) begin
          pending_verdicts.push_back(fresh);
        end
      end

      if (out_tvalid && out_tready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t unexpected verdict: expected none, actual %h", $time, out_tdata);
          errs++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_tdata[2:0] !== want.status) begin
            $display("%0t verdict code: expected %0d, actual %0d",
                     $time, want.status, out_tdata[2:0]);
            errs++;
          end
          if (out_tdata[18:3] !== want.crc) begin
            $display("%0t computed crc: expected %h, actual %h",
                     $time, want.crc, out_tdata[18:3]);
            errs++;
          end
          if (out_tdata[23:19] !== 5'd0) begin
            $display("%0t result padding: expected %h, actual %h",
                     $time, 5'd0, out_tdata[23:19]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    verdicts_due <= pending_verdicts.size();
  end

endmodule

>>> tb/tb.sv
// stimulus and verdict for the modbus rtu response checker
`timescale 1ns / 100ps

module tb;
  import mrc_pkg::*;
  import mrc_tb_pkg::*;

  localparam int         CLK_PERIOD        = 8;
  localparam int         CYCLE_LIMIT       = 1000000;
  localparam int         ITEM_TARGET       = 1300;
  localparam int         QUIET_CYCLES      = 12;
  localparam logic [7:0] FN_WRITE_MULTIPLE = 8'h10;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_ADDR, FR_BAD_FUNC, FR_BAD_COUNT,
                FR_CUT, FR_JUNK} frame_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  int fail_count;
  int verdicts_due;
  int cycle_cnt;
  int bytes_sent;
  bit src_calm;
  bit sink_calm;
  int unsigned sink_wait;
  int unsigned sink_roll;

  logic [7:0] cur_addr;
  logic [7:0] cur_func;
  logic [6:0] cur_regs;

  modbus_rtu_response_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  modbus_rtu_response_monitor chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .verdicts_due (verdicts_due)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // result side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait  <= 0;
    end else if (sink_wait > 1) begin
      sink_wait <= sink_wait - 1;
    end else if (sink_wait == 1) begin
      sink_wait  <= 0;
      out_tready <= 1'b1;
    end else begin
      sink_roll = sink_calm ? 0 : idle_len();
      sink_wait  <= sink_roll;
      out_tready <= (sink_roll == 0);
      if ($urandom_range(0, 249) == 0) begin
        sink_calm <= !sink_calm;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit st);
    int unsigned gap;
    gap = src_calm ? 0 : idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= st;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if ($urandom_range(0, 299) == 0) begin
      src_calm = !src_calm;
    end
  endtask

  // nothing due and the pipe has had time to empty
  task automatic wait_drained();
    int quiet;
    quiet = 0;
    while (quiet < QUIET_CYCLES) begin
      @(posedge clk);
      if (verdicts_due == 0) begin
        quiet++;
      end else begin
        quiet = 0;
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [7:0] a, input logic [7:0] f, input logic [6:0] n);
    in_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_EXP_ADDRESS, a);
    write_reg(REG_EXP_FUNCTION, f);
    write_reg(REG_REQ_COUNT, {1'b0, n});
    cfg_valid <= 1'b0;
    cur_addr = a;
    cur_func = f;
    cur_regs = n;
  endtask

  task automatic send_frame(input frame_kind_t kind, input bit odd_count);
    logic [7:0]  fb[$];
    logic [7:0]  flip;
    logic [6:0]  nflip;
    logic [7:0]  cnt;
    logic [15:0] acc;
    int          n;
    int          keep;
    if (kind == FR_JUNK) begin
      repeat ($urandom_range(1, 4)) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      return;
    end
    flip = 8'($urandom_range(1, 255));
    fb.push_back(kind == FR_BAD_ADDR ? cur_addr ^ flip : cur_addr);
    flip = 8'($urandom_range(1, 255));
    fb.push_back(kind == FR_BAD_FUNC ? cur_func ^ flip : cur_func);
    cnt = {cur_regs, odd_count};
    if (kind == FR_BAD_COUNT) begin
      nflip = 7'($urandom_range(1, 127));
      cnt   = cnt ^ {nflip, 1'b0};
    end
    fb.push_back(cnt);
    n = int'(cnt);
    // the tail of an early-rejected frame is only ignored, keep it short
    if (kind inside {FR_BAD_ADDR, FR_BAD_FUNC, FR_BAD_COUNT} && n > 6) begin
      n = 6;
    end
    for (int i = 0; i < n; i++) begin
      fb.push_back(8'($urandom_range(0, 255)));
    end
    acc = CRC_INIT;
    foreach (fb[i]) begin
      acc = modbus_crc_next(acc, fb[i]);
    end
    if (kind == FR_BAD_CRC) begin
      acc = acc ^ (16'h0001 << $urandom_range(0, 15));
    end
    fb.push_back(acc[7:0]);
    fb.push_back(acc[15:8]);
    if (kind == FR_CUT) begin
      keep = $urandom_range(1, fb.size() - 1);
      while (fb.size() > keep) begin
        void'(fb.pop_back());
      end
    end
    foreach (fb[i]) begin
      send_byte(fb[i], i == 0);
    end
  endtask

  initial begin
    int          phase_no;
    int unsigned r;
    logic [7:0]  a;
    logic [7:0]  f;
    logic [6:0]  n;
    int          nframes;
    frame_kind_t kind;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    cycle_cnt  = 0;
    bytes_sent = 0;
    src_calm   = 1'b0;
    sink_calm  = 1'b0;
    cur_addr   = '0;
    cur_func   = '0;
    cur_regs   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ignored before any frame start
    send_byte(8'hFF, 1'b0);
    // reset setup: address 0, function 0 matches but is unsupported
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);

    set_config(8'hFF, FN_READ_INPUT, 7'd0);
    send_frame(FR_GOOD, 1'b0);
    send_frame(FR_GOOD, 1'b1);          // odd byte count, one data byte
    send_byte(8'h00, 1'b1);             // wrong address
    send_byte(FN_READ_INPUT, 1'b0);
    send_byte(8'hFF, 1'b1);             // count says one register, none asked
    send_byte(FN_READ_INPUT, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b1);             // frame dropped by a new start
    send_byte(FN_READ_INPUT, 1'b0);
    send_frame(FR_BAD_CRC, 1'b0);

    phase_no = 0;
    while (bytes_sent < ITEM_TARGET) begin
      case (phase_no)
        0: set_config(8'h00, FN_READ_HOLDING, 7'd125);
        1: set_config(8'hFF, FN_WRITE_MULTIPLE, 7'd1);
        default: begin
          r = $urandom_range(0, 99);
          a = (r < 20) ? 8'h00 : (r < 40) ? 8'hFF : 8'($urandom_range(0, 255));
          r = $urandom_range(0, 99);
          f = (r < 40) ? FN_READ_HOLDING : (r < 80) ? FN_READ_INPUT
                                                    : 8'($urandom_range(0, 255));
          r = $urandom_range(0, 99);
          n = (r < 6) ? 7'd125 : (r < 20) ? 7'($urandom_range(7, 40))
                                          : 7'($urandom_range(0, 6));
          set_config(a, f, n);
        end
      endcase
      nframes = (cur_regs > 20) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      repeat (nframes) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        r = $urandom_range(0, 99);
        kind = (r < 55) ? FR_GOOD : (r < 67) ? FR_BAD_CRC : (r < 75) ? FR_BAD_ADDR :
               (r < 83) ? FR_BAD_FUNC : (r < 91) ? FR_BAD_COUNT : (r < 96) ? FR_CUT : FR_JUNK;
        send_frame(kind, 1'($urandom_range(0, 1)));
      end
      phase_no++;
    end

    in_tvalid <= 1'b0;
    wait_drained();
    if (fail_count == 0 && verdicts_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/mrc_pkg.sv
hw/rtl/mrc_cfg_regs.sv
hw/rtl/mrc_frame_ctl.sv
hw/rtl/modbus_rtu_response_checker.sv
tb/modbus_rtu_response_checker_monitor.sv
tb/tb.sv
